// ----- design/ssfp_pkg.sv -----
// Shared types and codes for the servo status frame parser.
package ssfp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OC_W   = 3;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] ID_RESET     = 8'h01;

    typedef enum logic [OC_W-1:0] {
        OC_OK     = 3'd0,
        OC_HEADER = 3'd1,
        OC_ID     = 3'd2,
        OC_LENGTH = 3'd3,
        OC_SERVO  = 3'd4,
        OC_CHECK  = 3'd5
    } t_outcome;

    typedef struct packed {
        logic [BYTE_W-1:0] header_value;
        logic [BYTE_W-1:0] expected_id;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              end_of_packet;
        t_outcome          outcome;
        logic [BYTE_W-1:0] servo_status;
    } t_result;

endpackage

// ----- design/ssfp_cfg_regs.sv -----
// APB register file: header value and expected servo ID.
module ssfp_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ssfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssfp_pkg::DATA_W-1:0]  pwdata,
    output logic [ssfp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ssfp_pkg::t_cfg               o_cfg
);
    import ssfp_pkg::*;

    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_ID     = 1'b1;

    logic       w_write;
    logic       w_sel;
    logic [BYTE_W-1:0] r_header;
    logic [BYTE_W-1:0] r_id;

    assign pready  = 1'b1;
    assign w_sel   = paddr[ADDR_W-1];
    assign w_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= HEADER_RESET;
            r_id     <= ID_RESET;
        end else if (w_write) begin
            unique case (w_sel)
                REG_HEADER: r_header <= pwdata[BYTE_W-1:0];
                REG_ID:     r_id     <= pwdata[BYTE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_sel)
            REG_HEADER: prdata[BYTE_W-1:0] = r_header;
            REG_ID:     prdata[BYTE_W-1:0] = r_id;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = '{header_value: r_header, expected_id: r_id};

endmodule

// ----- design/ssfp_parse_core.sv -----
// Packet phase tracking, checksum accumulation and per-byte result decode.
module ssfp_parse_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [ssfp_pkg::BYTE_W-1:0] i_byte,
    input  ssfp_pkg::t_cfg              i_cfg,
    output logic                        o_hit,
    output ssfp_pkg::t_result           o_res
);
    import ssfp_pkg::*;

    localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

    typedef enum logic [2:0] {
        PH_HDR1   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_ID     = 3'd2,
        PH_LEN    = 3'd3,
        PH_STATUS = 3'd4,
        PH_BODY   = 3'd5
    } t_phase;

    t_phase            r_phase,      n_phase;
    logic              r_first_ok,   n_first_ok;
    logic [BYTE_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0] r_sum,        n_sum;
    logic [BYTE_W-1:0] r_status,     n_status;
    logic              w_restart;

    always_comb begin
        n_phase      = r_phase;
        n_first_ok   = r_first_ok;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_status     = r_status;
        w_restart    = 1'b0;
        o_hit        = 1'b0;
        o_res        = '{payload_byte: '0, end_of_packet: 1'b0,
                         outcome: OC_OK, servo_status: r_status};

        unique case (r_phase)
            PH_HDR2: begin
                if (r_first_ok && (i_byte == i_cfg.header_value)) begin
                    n_phase = PH_ID;
                end else begin
                    o_hit                = 1'b1;
                    o_res.end_of_packet  = 1'b1;
                    o_res.outcome        = OC_HEADER;
                    o_res.servo_status   = '0;
                    w_restart            = 1'b1;
                end
            end
            PH_ID: begin
                if (i_byte != i_cfg.expected_id) begin
                    o_hit               = 1'b1;
                    o_res.end_of_packet = 1'b1;
                    o_res.outcome       = OC_ID;
                    w_restart           = 1'b1;
                end else begin
                    n_sum   = i_byte;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_byte < MIN_LEN) begin
                    o_hit               = 1'b1;
                    o_res.end_of_packet = 1'b1;
                    o_res.outcome       = OC_LENGTH;
                    w_restart           = 1'b1;
                end else begin
                    n_sum        = r_sum + i_byte;
                    n_bytes_left = i_byte - 8'd1;
                    n_phase      = PH_STATUS;
                end
            end
            PH_STATUS: begin
                n_status = i_byte;
                n_sum    = r_sum + i_byte;
                n_phase  = PH_BODY;
            end
            PH_BODY: begin
                o_hit = 1'b1;
                if (r_bytes_left > 8'd1) begin
                    // payload byte: pass through and fold into the sum
                    n_sum              = r_sum + i_byte;
                    n_bytes_left       = r_bytes_left - 8'd1;
                    o_res.payload_byte = i_byte;
                end else begin
                    // checksum byte: servo error wins over a bad checksum
                    o_res.end_of_packet = 1'b1;
                    if (r_status != '0) begin
                        o_res.outcome = OC_SERVO;
                    end else if (~r_sum != i_byte) begin
                        o_res.outcome = OC_CHECK;
                    end else begin
                        o_res.outcome = OC_OK;
                    end
                    w_restart = 1'b1;
                end
            end
            default: begin
                // first header byte; unused codes land here too
                n_phase      = PH_HDR2;
                n_first_ok   = (i_byte == i_cfg.header_value);
                n_bytes_left = '0;
                n_sum        = '0;
                n_status     = '0;
            end
        endcase

        if (w_restart) begin
            n_phase      = PH_HDR1;
            n_first_ok   = 1'b0;
            n_bytes_left = '0;
            n_sum        = '0;
            n_status     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HDR1;
            r_first_ok   <= 1'b0;
            r_bytes_left <= '0;
            r_sum        <= '0;
            r_status     <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_first_ok   <= n_first_ok;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_status     <= n_status;
        end
    end

endmodule

// ----- design/servo_status_frame_parser_unit.sv -----
// Latency: a result is valid in the cycle after the byte transfer that causes it.
// Throughput: one received byte per cycle; the output register frees up in the
//   same cycle its result is taken, so input stalls only while a result waits.
// Reset (synchronous, active low): parser back to hunting the first header byte,
//   header value 0xFF, expected ID 0x01, output register empty.
// Config writes take effect at the APB access edge; pready is tied high.
module servo_status_frame_parser_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // receive byte channel
    input  logic                        i_rx_valid,
    output logic                        o_rx_ready,
    input  logic [ssfp_pkg::BYTE_W-1:0] i_rx_byte,
    // result channel
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [ssfp_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                        o_end_of_packet,
    output logic [ssfp_pkg::OC_W-1:0]   o_outcome,
    output logic [ssfp_pkg::BYTE_W-1:0] o_servo_status,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssfp_pkg::ADDR_W-1:0] paddr,
    input  logic [ssfp_pkg::DATA_W-1:0] pwdata,
    output logic [ssfp_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ssfp_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_hit;
    logic    w_accept;

    logic    r_res_valid;
    t_result r_res;

    ssfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // The byte is decoded in the cycle of its transfer; state advances at that edge.
    ssfp_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (i_rx_byte),
        .i_cfg    (w_cfg),
        .o_hit    (w_hit),
        .o_res    (w_res)
    );

    // Output register: a new byte is taken when the slot is empty or draining now.
    assign o_rx_ready = !r_res_valid || i_res_ready;
    assign w_accept   = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_accept) begin
            r_res_valid <= w_hit;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept && w_hit) begin
            r_res <= w_res;
        end
    end

    assign o_res_valid     = r_res_valid;
    assign o_payload_byte  = r_res.payload_byte;
    assign o_end_of_packet = r_res.end_of_packet;
    assign o_outcome       = r_res.outcome;
    assign o_servo_status  = r_res.servo_status;

`ifndef SYNTHESIS
    // end results never carry a payload byte
    a_eop_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.end_of_packet) |-> (r_res.payload_byte == '0))
        else $error("end result carries payload byte");

    // payload results always report ok
    a_payload_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && !r_res.end_of_packet) |-> (r_res.outcome == OC_OK))
        else $error("payload result with nonzero outcome");

    // early aborts happen before the status byte, so status must read zero
    a_abort_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && (r_res.outcome == OC_HEADER || r_res.outcome == OC_ID ||
                         r_res.outcome == OC_LENGTH))
        |-> (r_res.servo_status == '0))
        else $error("header/id/length abort reports a status byte");

    // servo error outcome only with a nonzero status
    a_servo_err_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.outcome == OC_SERVO) |-> (r_res.servo_status != '0))
        else $error("servo error outcome with zero status");
`endif

endmodule

// ----- tb/servo_status_frame_parser_unit_tb.sv -----
// Self-checking testbench for the servo status frame parser unit.
`timescale 1ns / 1ps

module servo_status_frame_parser_unit_tb;

    import ssfp_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam time CLK_PERIOD   = 12ns;
    localparam int  RESET_CYCLES = 7;
    localparam int  ITEM_TARGET  = 1650;     // rough size of the byte stream
    localparam int  TRAFFIC_SETS = 6;        // register settings in the random part
    localparam int  MAX_GAP      = 6;        // longest idle/stall per transfer
    localparam int  SETTLE_CYCLES = 4;       // settle time after the last expected result

    // APB register map: one 32-bit word per register
    localparam logic [ADDR_W-1:0] ADDR_HEADER = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_ID     = ADDR_W'(4);

    // Parser position inside a status frame, as tracked by the predictor
    typedef enum logic [2:0] {
        FRM_HDR1,
        FRM_HDR2,
        FRM_ID,
        FRM_LEN,
        FRM_STATUS,
        FRM_BODY
    } t_frame_step;

    // How payload bytes of a generated frame are filled
    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES
    } t_fill;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic               i_clk     = 1'b0;
    logic               i_rst_n   = 1'b0;
    logic               rx_valid  = 1'b0;
    logic               rx_ready;
    logic [BYTE_W-1:0]  rx_byte   = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic [BYTE_W-1:0]  payload_byte;
    logic               end_of_packet;
    logic [OC_W-1:0]    outcome;
    logic [BYTE_W-1:0]  servo_status;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [ADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]  pwdata    = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    servo_status_frame_parser_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (rx_valid),
        .o_rx_ready      (rx_ready),
        .i_rx_byte       (rx_byte),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_payload_byte  (payload_byte),
        .o_end_of_packet (end_of_packet),
        .o_outcome       (outcome),
        .o_servo_status  (servo_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: register copies plus the frame parser itself
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] cfg_header = HEADER_RESET;
    logic [BYTE_W-1:0] cfg_id     = ID_RESET;
    t_frame_step       frm_step   = FRM_HDR1;
    logic              hdr1_match = 1'b0;
    logic [BYTE_W-1:0] left_cnt   = '0;  // bytes due after status, checksum included
    logic [BYTE_W-1:0] sum_acc    = '0;  // id + length + status + payload, mod 256
    logic [BYTE_W-1:0] status_acc = '0;  // status byte of the frame in progress

    t_result expected_results[$];        // oldest expectation at the front

    // Bookkeeping
    int  errors          = 0;
    int  bytes_sent      = 0;
    int  frames_started  = 0;
    int  results_checked = 0;
    int  end_counts[6];
    bit  no_gaps         = 1'b0;   // burst mode: both sides stop idling

    // ------------------------------------------------------------------
    // Clock, and a hard stop should the stream ever hang
    // ------------------------------------------------------------------
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // The slowest legal run takes about 300 us; this leaves a wide margin.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_frame();
        frm_step   = FRM_HDR1;
        hdr1_match = 1'b0;
        left_cnt   = '0;
        sum_acc    = '0;
        status_acc = '0;
    endfunction

    // Advance the parser copy by one received byte and queue the result it
    // produces, if any. Servo status is captured before the frame is cleared.
    function automatic void predict_rx(input logic [BYTE_W-1:0] b);
        t_result r;
        bit      produced;
        r        = '0;
        produced = 1'b0;
        case (frm_step)
            FRM_HDR2: begin
                // header pair is judged only once both bytes are in
                if (hdr1_match && b == cfg_header) begin
                    frm_step = FRM_ID;
                end else begin
                    status_acc      = '0;
                    r.end_of_packet = 1'b1;
                    r.outcome       = OC_HEADER;
                    produced        = 1'b1;
                end
            end
            FRM_ID: begin
                if (b != cfg_id) begin
                    r.end_of_packet = 1'b1;
                    r.outcome       = OC_ID;
                    produced        = 1'b1;
                end else begin
                    sum_acc  = b;
                    frm_step = FRM_LEN;
                end
            end
            FRM_LEN: begin
                if (b < 8'd2) begin
                    r.end_of_packet = 1'b1;
                    r.outcome       = OC_LENGTH;
                    produced        = 1'b1;
                end else begin
                    sum_acc  = sum_acc + b;
                    left_cnt = b - 8'd1;
                    frm_step = FRM_STATUS;
                end
            end
            FRM_STATUS: begin
                status_acc = b;
                sum_acc    = sum_acc + b;
                frm_step   = FRM_BODY;
            end
            FRM_BODY: begin
                produced = 1'b1;
                if (left_cnt > 8'd1) begin
                    // payload byte goes out even when the status flags an error
                    sum_acc        = sum_acc + b;
                    left_cnt       = left_cnt - 8'd1;
                    r.payload_byte = b;
                    r.outcome      = OC_OK;
                end else begin
                    // checksum byte: servo error wins over a bad checksum
                    r.end_of_packet = 1'b1;
                    if (status_acc != '0)
                        r.outcome = OC_SERVO;
                    else if ((~sum_acc) != b)
                        r.outcome = OC_CHECK;
                    else
                        r.outcome = OC_OK;
                end
            end
            default: begin
                clear_frame();
                hdr1_match = (b == cfg_header);
                frm_step   = FRM_HDR2;
            end
        endcase
        if (produced) begin
            r.servo_status = status_acc;
            expected_results.push_back(r);
            if (r.end_of_packet)
                clear_frame();
        end
    endfunction

    // ------------------------------------------------------------------
    // Receive-byte driver: random idle before each transfer, valid held
    // high across back-to-back transfers.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge i_clk); while (!rx_ready);
        predict_rx(b);
        bytes_sent++;
    endtask

    // Builds one status frame with the current header value. Any leftover
    // partial frame is flushed with random bytes first so the frame lines up.
    // Stops early after a wrong ID or a short length, as the parser does.
    task automatic send_frame(input logic [BYTE_W-1:0] id, input int len,
                              input logic [BYTE_W-1:0] status, input t_fill fill,
                              input bit bad_sum);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] pb;
        while (frm_step != FRM_HDR1)
            send_byte(BYTE_W'($urandom_range(0, 255)));
        frames_started++;
        send_byte(cfg_header);
        send_byte(cfg_header);
        send_byte(id);
        if (id != cfg_id)
            return;
        send_byte(BYTE_W'(len));
        if (len < 2)
            return;
        send_byte(status);
        sum = id + BYTE_W'(len) + status;
        for (int k = 0; k < len - 2; k++) begin
            case (fill)
                FILL_ZERO: pb = 8'h00;
                FILL_ONES: pb = 8'hFF;
                default:   pb = BYTE_W'($urandom_range(0, 255));
            endcase
            sum = sum + pb;
            send_byte(pb);
        end
        pb = ~sum;
        if (bad_sum)
            pb = pb ^ BYTE_W'($urandom_range(1, 255));
        send_byte(pb);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_HEADER: cfg_header = value;
            ADDR_ID:     cfg_id     = value;
            default:     ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result checker: random stall per result, field-by-field compare
    // against the oldest expectation.
    // ------------------------------------------------------------------
    initial begin : result_checker
        int      hold;
        t_result want;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n)
                continue;
            if (res_valid && res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: payload_byte %0h eop %0b outcome %0d",
                           payload_byte, end_of_packet, outcome);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.end_of_packet)
                        end_counts[want.outcome]++;
                    if (payload_byte !== want.payload_byte) begin
                        $error("payload_byte: expected %0h, actual %0h",
                               want.payload_byte, payload_byte);
                        errors++;
                    end
                    if (end_of_packet !== want.end_of_packet) begin
                        $error("end_of_packet: expected %0b, actual %0b",
                               want.end_of_packet, end_of_packet);
                        errors++;
                    end
                    if (outcome !== want.outcome) begin
                        $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
                        errors++;
                    end
                    if (servo_status !== want.servo_status) begin
                        $error("servo_status: expected %0h, actual %0h",
                               want.servo_status, servo_status);
                        errors++;
                    end
                end
                hold = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end else if (hold != 0) begin
                hold--;
            end
            res_ready <= (hold == 0);
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Reset values of both registers: a minimal frame (no payload) and a frame with one zero payload byte pass.
    task automatic test_reset_config_frames();
        send_frame(ID_RESET, 2, 8'h00, FILL_RANDOM, 1'b0);
        send_frame(ID_RESET, 3, 8'h00, FILL_ZERO, 1'b0);
    endtask

    // Header pair: first bad, second bad, both bad. Each pair gives one
    // bad-header end and the parser starts over on the next byte.
    task automatic test_header_errors();
        send_byte(8'h00);
        send_byte(cfg_header);
        send_byte(cfg_header);
        send_byte(cfg_header ^ 8'h01);
        send_byte(8'h00);
        send_byte(8'h7F);
    endtask

    // Wrong ID, then lengths 0 and 1 are both rejected.
    task automatic test_id_and_length_errors();
        send_frame(cfg_id ^ 8'h80, 2, 8'h00, FILL_RANDOM, 1'b0);
        send_frame(cfg_id, 0, 8'h00, FILL_RANDOM, 1'b0);
        send_frame(cfg_id, 1, 8'h00, FILL_RANDOM, 1'b0);
    endtask

    // Checksum-byte outcomes: servo error over a bad checksum (payload still
    // emitted), servo error alone, checksum mismatch alone.
    task automatic test_status_precedence();
        send_frame(cfg_id, 3, 8'h80, FILL_ONES, 1'b1);
        send_frame(cfg_id, 2, 8'hFF, FILL_RANDOM, 1'b0);
        send_frame(cfg_id, 4, 8'h00, FILL_ZERO, 1'b1);
    endtask

    // Register extremes: header 0x00 with ID 0xFF, then header 0xFF with ID 0x00.
    task automatic test_config_extremes();
        wait_idle();
        cfg_write(ADDR_HEADER, 8'h00);
        cfg_write(ADDR_ID, 8'hFF);
        send_frame(8'hFF, 3, 8'h00, FILL_ONES, 1'b0);
        wait_idle();
        cfg_write(ADDR_HEADER, 8'hFF);
        cfg_write(ADDR_ID, 8'h00);
        send_frame(8'h00, 3, 8'h00, FILL_ZERO, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic over several register settings. Mostly well-formed
    // frames with random content; the rest is line noise and broken frames.
    // ------------------------------------------------------------------
    task automatic test_random_traffic();
        int                pick;
        int                len;
        int                target;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] status;
        for (int set = 0; set < TRAFFIC_SETS; set++) begin
            wait_idle();
            case (set)
                0: begin
                    cfg_write(ADDR_HEADER, HEADER_RESET);
                    cfg_write(ADDR_ID, ID_RESET);
                end
                1: begin
                    cfg_write(ADDR_HEADER, 8'h00);
                    cfg_write(ADDR_ID, 8'h00);
                end
                2: begin
                    cfg_write(ADDR_HEADER, 8'hFF);
                    cfg_write(ADDR_ID, 8'hFF);
                end
                default: begin
                    cfg_write(ADDR_HEADER, BYTE_W'($urandom_range(0, 255)));
                    cfg_write(ADDR_ID, BYTE_W'($urandom_range(0, 255)));
                end
            endcase
            target = ITEM_TARGET * (set + 1) / TRAFFIC_SETS;
            while (bytes_sent < target) begin
                // occasional switch into or out of back-to-back bursts
                if ($urandom_range(0, 15) == 0)
                    no_gaps = !no_gaps;
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    id     = ($urandom_range(0, 19) == 0) ? BYTE_W'($urandom_range(0, 255))
                                                          : cfg_id;
                    len    = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 255)
                                                          : $urandom_range(2, 10);
                    status = ($urandom_range(0, 9) < 7) ? 8'h00
                                                        : BYTE_W'($urandom_range(0, 255));
                    send_frame(id, len, status, FILL_RANDOM, $urandom_range(0, 4) == 0);
                end else if (pick < 83) begin
                    repeat ($urandom_range(1, 5))
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                end else if (pick < 90) begin
                    // header pair with each byte right or wrong at random
                    repeat (2)
                        send_byte($urandom_range(0, 1) ? cfg_header
                                                       : BYTE_W'($urandom_range(0, 255)));
                end else if (pick < 95) begin
                    send_frame(cfg_id, $urandom_range(0, 1), 8'h00, FILL_RANDOM, 1'b0);
                end else begin
                    send_frame(cfg_id ^ BYTE_W'($urandom_range(1, 255)), 2, 8'h00,
                               FILL_RANDOM, 1'b0);
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config_frames();
        test_header_errors();
        test_id_and_length_errors();
        test_status_precedence();
        test_config_extremes();
        test_random_traffic();

        // drain every expected result, then a few more cycles for stragglers
        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d frames over %0d register settings; %0d results checked.",
                 bytes_sent, frames_started, TRAFFIC_SETS + 2, results_checked);
        $display("Frame ends: ok %0d, header %0d, id %0d, length %0d, servo %0d, checksum %0d.",
                 end_counts[OC_OK], end_counts[OC_HEADER], end_counts[OC_ID],
                 end_counts[OC_LENGTH], end_counts[OC_SERVO], end_counts[OC_CHECK]);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
